>>> hdl/slfp_pkg.sv
package slfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned SumW     = 16;
  localparam int unsigned CountOutW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // Parser phase codes; any other code hunts for the first sync byte.
  localparam logic [PhaseW-1:0] PH_SYNC1  = 4'd0;
  localparam logic [PhaseW-1:0] PH_SYNC2  = 4'd1;
  localparam logic [PhaseW-1:0] PH_TYPE   = 4'd2;
  localparam logic [PhaseW-1:0] PH_SEQ    = 4'd3;
  localparam logic [PhaseW-1:0] PH_LEN    = 4'd4;
  localparam logic [PhaseW-1:0] PH_DATA   = 4'd5;
  localparam logic [PhaseW-1:0] PH_SUM_LO = 4'd6;
  localparam logic [PhaseW-1:0] PH_SUM_HI = 4'd7;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_HEADER   = 3'd0;
  localparam logic [StatusW-1:0] ST_PAYLOAD  = 3'd1;
  localparam logic [StatusW-1:0] ST_GOOD     = 3'd2;
  localparam logic [StatusW-1:0] ST_SYNC_ERR = 3'd3;
  localparam logic [StatusW-1:0] ST_SUM_ERR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 1'b1;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [ByteW-1:0]     payload_byte;
    logic [ByteW-1:0]     payload_index;
    logic [ByteW-1:0]     frame_type;
    logic [ByteW-1:0]     frame_sequence;
    logic [ByteW-1:0]     frame_length;
    logic [CountOutW-1:0] sync_error_count;
    logic [CountOutW-1:0] checksum_error_count;
  } slfp_result_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
  } slfp_core_stat_t;

endpackage

>>> hdl/sync_length_frame_parser.sv
// Frame receiver for a byte stream framed as: sync_first, sync_second, type,
// sequence, length, <length> payload bytes, checksum low byte, high byte.
// The checksum is the 16-bit wrapping sum of type, sequence, length and payload.
// Input channel: one received byte per request on rx_byte_i, taken at a clock
// edge where in_valid_i is high and in_stall_o is low.
// Output channel: exactly one result per input byte, in order, with status,
// payload byte and index, current frame header fields and the two error counts.
// Output stage: each result is registered before it is presented.
// Throughput: one byte per cycle while in_stall_o is low; the parser step is one
// compare-and-add between the frame state registers and the result register.
// Configuration: cfg_we_i writes sync_first (index 0) or sync_second (index 1);
// write only while no results are outstanding.
// Reset: hunt for the first sync byte, clear frame fields, sum and error
// counts, set both sync bytes to zero and empty the output stage.
// Receiver stall: the result register holds; one more request lands in a skid
// register, after which in_stall_o rises until the output drains.
module sync_length_frame_parser #(
  parameter int unsigned ERROR_COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slfp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [slfp_pkg::ByteW-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [slfp_pkg::ByteW-1:0]      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [slfp_pkg::StatusW-1:0]    status_o,
  output logic [slfp_pkg::ByteW-1:0]      payload_byte_o,
  output logic [slfp_pkg::ByteW-1:0]      payload_index_o,
  output logic [slfp_pkg::ByteW-1:0]      frame_type_o,
  output logic [slfp_pkg::ByteW-1:0]      frame_sequence_o,
  output logic [slfp_pkg::ByteW-1:0]      frame_length_o,
  output logic [slfp_pkg::CountOutW-1:0]  sync_error_count_o,
  output logic [slfp_pkg::CountOutW-1:0]  checksum_error_count_o
);
  import slfp_pkg::*;

  logic            in_accept;
  slfp_result_t    step_res;
  slfp_result_t    out_res;
  slfp_core_stat_t core_stat;

  // A byte is taken whenever the skid stage has room.
  assign in_accept = in_valid_i && !in_stall_o;

  slfp_core #(
    .ERROR_COUNT_WIDTH(ERROR_COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .result_o    (step_res),
    .stat_o      (core_stat)
  );

  // Result register plus one skid entry; decouple the stall path.
  slfp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (step_res),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_stall_i (out_stall_i)
  );

  assign status_o               = out_res.status;
  assign payload_byte_o         = out_res.payload_byte;
  assign payload_index_o        = out_res.payload_index;
  assign frame_type_o           = out_res.frame_type;
  assign frame_sequence_o       = out_res.frame_sequence;
  assign frame_length_o         = out_res.frame_length;
  assign sync_error_count_o     = out_res.sync_error_count;
  assign checksum_error_count_o = out_res.checksum_error_count;

  // Input stalls only while a result is already held at the output.
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output stage");

  // Payload fields stay zero outside payload bytes.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && step_res.status != ST_PAYLOAD
      |-> step_res.payload_byte == '0 && step_res.payload_index == '0)
    else $error("payload fields set on a non-payload result");

  // Any error, and a good frame end, sends the parser back to the sync hunt.
  a_error_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (step_res.status == ST_SYNC_ERR || step_res.status == ST_SUM_ERR
                  || step_res.status == ST_GOOD)
      |=> core_stat.phase == PH_SYNC1)
    else $error("parser did not return to sync hunt after frame end");

endmodule

>>> hdl/slfp_core.sv
module slfp_core #(
  parameter int unsigned ERROR_COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [slfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [slfp_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          accept_i,
  input  logic [slfp_pkg::ByteW-1:0]    rx_byte_i,
  output slfp_pkg::slfp_result_t        result_o,
  output slfp_pkg::slfp_core_stat_t     stat_o
);
  import slfp_pkg::*;

  localparam int unsigned CntW = ERROR_COUNT_WIDTH;

  logic [ByteW-1:0]  sync_first_q, sync_second_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [ByteW-1:0]  count_q, count_d;
  logic [ByteW-1:0]  type_q, type_d;
  logic [ByteW-1:0]  seq_q, seq_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [CntW-1:0]   sync_err_q, sync_err_d;
  logic [CntW-1:0]   sum_err_q, sum_err_d;
  logic [ByteW-1:0]  count_inc;
  logic [SumW-1:0]   sum_add;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]  pbyte, pindex;
  logic [31:0]       sync_err_ext, sum_err_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign count_inc = count_q + 8'd1;
  assign sum_add   = sum_q + SumW'(rx_byte_i);

  always_comb begin
    phase_d    = PH_SYNC1;
    sum_d      = sum_q;
    count_d    = count_q;
    type_d     = type_q;
    seq_d      = seq_q;
    len_d      = len_q;
    sync_err_d = sync_err_q;
    sum_err_d  = sum_err_q;
    status     = ST_HEADER;
    pbyte      = '0;
    pindex     = '0;
    case (phase_q)
      PH_SYNC2: begin
        if (rx_byte_i == sync_second_q) begin
          phase_d = PH_TYPE;
        end else begin
          status     = ST_SYNC_ERR;
          sync_err_d = (sync_err_q == '1) ? sync_err_q : sync_err_q + 1'b1;
        end
      end
      PH_TYPE: begin
        type_d  = rx_byte_i;
        sum_d   = SumW'(rx_byte_i);
        phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        seq_d   = rx_byte_i;
        sum_d   = sum_add;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d   = rx_byte_i;
        sum_d   = sum_add;
        count_d = '0;
        phase_d = (rx_byte_i == '0) ? PH_SUM_LO : PH_DATA;
      end
      PH_DATA: begin
        status = ST_PAYLOAD;
        pbyte  = rx_byte_i;
        pindex = count_q;
        sum_d  = sum_add;
        if (count_inc == len_q) begin
          count_d = '0;
          phase_d = PH_SUM_LO;
        end else begin
          count_d = count_inc;
          phase_d = PH_DATA;
        end
      end
      PH_SUM_LO: begin
        if (rx_byte_i == sum_q[7:0]) begin
          phase_d = PH_SUM_HI;
        end else begin
          status    = ST_SUM_ERR;
          sum_err_d = (sum_err_q == '1) ? sum_err_q : sum_err_q + 1'b1;
        end
      end
      PH_SUM_HI: begin
        if (rx_byte_i == sum_q[15:8]) begin
          status = ST_GOOD;
        end else begin
          status    = ST_SUM_ERR;
          sum_err_d = (sum_err_q == '1) ? sum_err_q : sum_err_q + 1'b1;
        end
      end
      default: begin
        if (rx_byte_i == sync_first_q) begin
          phase_d = PH_SYNC2;
        end else begin
          status     = ST_SYNC_ERR;
          sync_err_d = (sync_err_q == '1) ? sync_err_q : sync_err_q + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC1;
      sum_q      <= '0;
      count_q    <= '0;
      type_q     <= '0;
      seq_q      <= '0;
      len_q      <= '0;
      sync_err_q <= '0;
      sum_err_q  <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      sum_q      <= sum_d;
      count_q    <= count_d;
      type_q     <= type_d;
      seq_q      <= seq_d;
      len_q      <= len_d;
      sync_err_q <= sync_err_d;
      sum_err_q  <= sum_err_d;
    end
  end

  // Counters report their low 16 bits, zero-extended when narrower.
  assign sync_err_ext = 32'(sync_err_d);
  assign sum_err_ext  = 32'(sum_err_d);

  always_comb begin
    result_o.status               = status;
    result_o.payload_byte         = pbyte;
    result_o.payload_index        = pindex;
    result_o.frame_type           = type_d;
    result_o.frame_sequence       = seq_d;
    result_o.frame_length         = len_d;
    result_o.sync_error_count     = sync_err_ext[CountOutW-1:0];
    result_o.checksum_error_count = sum_err_ext[CountOutW-1:0];
  end

  assign stat_o.phase = phase_q;

endmodule

>>> hdl/slfp_skid.sv
module slfp_skid (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  slfp_pkg::slfp_result_t in_data_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output slfp_pkg::slfp_result_t out_data_o,
  input  logic                   out_stall_i
);
  import slfp_pkg::*;

  logic         main_valid_q, skid_valid_q;
  slfp_result_t main_q, skid_q;
  logic         accept, drain;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign drain      = !main_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (accept) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule
